[rtl/tmwf_pkg.sv]
// shared types and constants for the trimmed mean window filter
package tmwf_pkg;

   localparam int WINDOW_LEN   = 8;
   localparam int NUM_CHANNELS = 32;

   localparam int CHANNEL_W = 5;
   localparam int SAMPLE_W  = 12;

   localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
   localparam int CH_ADDR_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int TOTAL_W    = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);

   localparam int DIVISOR    = WINDOW_LEN - 2;
   localparam int SUM_W      = $clog2(DIVISOR * SAMPLE_MAX + 1);
   localparam int DIV_SHIFT  = SUM_W + $clog2(DIVISOR);
   localparam int RECIP      = ((1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam int RECIP_W    = SUM_W + 1;
   localparam int PROD_W     = SUM_W + RECIP_W;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] row_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      sample_type         min_val;
      sample_type         max_val;
   } stats_type;

endpackage

[rtl/trimmed_mean_window_filter_unit.sv]
// top level of the per-channel trimmed mean window filter
//
// Each request shifts its sample into the window of its channel and returns
// one response: the floor mean of the window without one minimum and one
// maximum, or the oldest sample when all window samples are equal. A new
// request is taken only while the read stage is empty, set by the
// read-modify-write of the channel row in the window memory (one row holds
// a whole window). The response is registered after the read stage and the
// reduce stage. Windows read as zero after reset through one valid bit per
// channel, so no clearing pass is needed. A channel at or above the number
// of channels leaves all windows unchanged and returns zero.
module trimmed_mean_window_filter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tmwf_pkg::CHANNEL_W-1:0]  req_channel,
   input  logic [tmwf_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tmwf_pkg::SAMPLE_W-1:0]   rsp_filtered
);

   tmwf_pkg::row_type window_mem [tmwf_pkg::NUM_CHANNELS];

   logic req_accept;

   // read stage
   logic                           s1_valid_ff, s1_valid_in;
   logic [tmwf_pkg::CH_ADDR_W-1:0] s1_addr_ff;
   logic                           s1_inrange_ff;
   logic                           s1_rowvalid_ff;
   tmwf_pkg::sample_type           s1_sample_ff;
   tmwf_pkg::row_type              s1_rdata_ff;

   logic [tmwf_pkg::NUM_CHANNELS-1:0] row_valid_ff, row_valid_in;

   // reduce stage
   logic                         s2_valid_ff, s2_valid_in;
   logic                         s2_inrange_ff;
   tmwf_pkg::stats_type          s2_stats_ff;
   tmwf_pkg::sample_type         s2_oldest_ff;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   tmwf_pkg::sample_type         rsp_filtered_ff;

   logic rsp_free, s2_free, s1_adv, s2_adv;
   logic req_inrange;

   tmwf_pkg::row_type   old_row;
   tmwf_pkg::row_type   new_row;
   tmwf_pkg::stats_type stats;

   logic [tmwf_pkg::SUM_W-1:0]  trimmed_sum;
   logic [tmwf_pkg::PROD_W-1:0] quot_prod;
   tmwf_pkg::sample_type        result;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s2_free    = !s2_valid_ff || rsp_free;
   assign s2_adv     = s2_valid_ff && rsp_free;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign req_stall  = s1_valid_ff;
   assign req_accept = req_valid && !s1_valid_ff;

   assign req_inrange = int'(req_channel) < tmwf_pkg::NUM_CHANNELS;

   // shift the new sample in at the newest slot
   assign old_row = s1_rowvalid_ff ? s1_rdata_ff : '0;
   assign new_row = {s1_sample_ff, old_row[tmwf_pkg::WINDOW_LEN-1:1]};

   tmwf_window_stats u_stats (
      .window (new_row),
      .stats  (stats)
   );

   // divide by the trimmed count through a reciprocal multiply
   assign trimmed_sum = tmwf_pkg::SUM_W'(s2_stats_ff.total
                                         - tmwf_pkg::TOTAL_W'(s2_stats_ff.min_val)
                                         - tmwf_pkg::TOTAL_W'(s2_stats_ff.max_val));
   assign quot_prod   = tmwf_pkg::PROD_W'(trimmed_sum)
                        * tmwf_pkg::PROD_W'(tmwf_pkg::RECIP);

   always_comb begin
      if (!s2_inrange_ff) begin
         result = '0;
      end else if (s2_stats_ff.min_val == s2_stats_ff.max_val) begin
         result = s2_oldest_ff;
      end else begin
         result = tmwf_pkg::SAMPLE_W'(quot_prod >> tmwf_pkg::DIV_SHIFT);
      end
   end

   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_adv ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      row_valid_in = row_valid_ff;
      if (s1_adv && s1_inrange_ff) begin
         row_valid_in[s1_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
      end
   end

   // window memory, one row per channel
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_rdata_ff <= window_mem[tmwf_pkg::CH_ADDR_W'(req_channel)];
      end
      if (s1_adv && s1_inrange_ff) begin
         window_mem[s1_addr_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff     <= tmwf_pkg::CH_ADDR_W'(req_channel);
         s1_inrange_ff  <= req_inrange;
         s1_rowvalid_ff <= row_valid_ff[tmwf_pkg::CH_ADDR_W'(req_channel)];
         s1_sample_ff   <= req_sample;
      end
      if (s1_adv) begin
         s2_inrange_ff <= s1_inrange_ff;
         s2_stats_ff   <= stats;
         s2_oldest_ff  <= new_row[0];
      end
      if (s2_adv) begin
         rsp_filtered_ff <= result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

endmodule

[rtl/tmwf_window_stats.sv]
// sum, minimum and maximum over one channel window
module tmwf_window_stats (
   input  tmwf_pkg::row_type   window,
   output tmwf_pkg::stats_type stats
);

   logic [tmwf_pkg::TOTAL_W-1:0] total;
   tmwf_pkg::sample_type         min_val;
   tmwf_pkg::sample_type         max_val;

   always_comb begin
      total   = tmwf_pkg::TOTAL_W'(window[0]);
      min_val = window[0];
      max_val = window[0];
      for (int k = 1; k < tmwf_pkg::WINDOW_LEN; k++) begin
         total = total + tmwf_pkg::TOTAL_W'(window[k]);
         if (window[k] < min_val) begin
            min_val = window[k];
         end
         if (window[k] > max_val) begin
            max_val = window[k];
         end
      end
   end

   assign stats.total   = total;
   assign stats.min_val = min_val;
   assign stats.max_val = max_val;

endmodule
